### sv/nsvl_pkg.sv
// Shared definitions for the nearest-seed labeller: field widths, item structs,
// controller state and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package nsvl_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_SEEDS_DEF  = 64;
	localparam int COORD_BITS_DEF = 10;

	// Fixed field widths of the item channels.
	localparam int SLOT_FW   = 6;
	localparam int COORD_FW  = 10;
	localparam int DIST_FW   = 21;
	localparam int COLOR_FW  = 26;
	localparam int COLOR_SHIFT = 16;

	// Configuration port.
	localparam int APB_DW     = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int ACTIVE_W   = 7;
	localparam logic [0:0] REG_ACTIVE_SEEDS = 1'b0;
	localparam logic [ACTIVE_W-1:0] ACTIVE_SEEDS_RESET = 7'd64;

	// Item operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [SLOT_FW-1:0]  seed_slot;
		logic [COORD_FW-1:0] coord_x;
		logic [COORD_FW-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_FW-1:0]  nearest_slot;
		logic [DIST_FW-1:0]  nearest_dist_sq;
		logic [COLOR_FW-1:0] region_color;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic pix_load;
		logic seed_wr;
		logic rd_en;
		logic out_load;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### sv/nsvl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module nsvl_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/nsvl_ctrl.sv
// Controller of the nearest-seed labeller: accepts items, sequences the table walk
// and releases the result. Depends on nsvl_pkg.
`default_nettype none

module nsvl_ctrl
	import nsvl_pkg::*;
#(
	parameter int MAX_SEEDS = MAX_SEEDS_DEF,
	localparam int SLOT_W = $clog2(MAX_SEEDS)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_opcode,
	output logic                     req_stall,
	input  wire logic [ACTIVE_W-1:0] active_seeds,
	output ctrl_cmd_t                cmd,
	input  wire dp_status_t          sts,
	output logic      [SLOT_W-1:0]   rd_addr
);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] addr_q;
	logic [SLOT_W-1:0] last_q;
	logic [SLOT_W-1:0] last_d;
	logic [31:0]       act_ext;
	logic [31:0]       cnt;
	logic              req_accept;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rd_addr    = addr_q;

	// Number of entries to search: a count of zero searches entry 0, and the count
	// saturates at the table depth.
	always_comb begin
		act_ext = 32'(active_seeds);
		priority if (act_ext == 32'd0) begin
			cnt = 32'd1;
		end else if (act_ext > 32'(MAX_SEEDS)) begin
			cnt = 32'(MAX_SEEDS);
		end else begin
			cnt = act_ext;
		end
		last_d = SLOT_W'(cnt - 32'd1);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept && (req_opcode == OP_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd.seed_wr  = req_accept && (req_opcode == OP_LOAD);
		cmd.pix_load = req_accept && (req_opcode == OP_QUERY);
		cmd.rd_en    = (state_q == ST_SCAN);
		cmd.out_load = (state_q == ST_DRAIN) && !sts.pipe_busy && sts.out_free;
	end

	// State register, walk address and last entry of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.pix_load) begin
				addr_q <= '0;
				last_q <= last_d;
			end else if (state_q == ST_SCAN) begin
				addr_q <= addr_q + SLOT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= last_q))
		else $error("walk address passed the last searched entry");

	a_release_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE))
		else $error("controller not idle after releasing a result");
`endif

endmodule

`default_nettype wire

### sv/nsvl_dp.sv
// Datapath of the nearest-seed labeller: seed table, distance pipeline, running
// minimum and output register. Depends on nsvl_pkg and nsvl_ram.
`default_nettype none

module nsvl_dp
	import nsvl_pkg::*;
#(
	parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int SLOT_W = $clog2(MAX_SEEDS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	input  wire logic [SLOT_W-1:0] rd_addr,
	input  wire in_item_t          req_item,
	output dp_status_t             sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output out_item_t              rsp_item
);

	localparam int CB     = COORD_BITS;
	localparam int SQW    = 2 * CB;
	localparam int DW     = 2 * CB + 1;
	localparam int SW_EXT = (SLOT_W > SLOT_FW) ? SLOT_W : SLOT_FW;

	logic [CB-1:0]     px_in, py_in;
	logic [SW_EXT-1:0] slot_ext;
	logic              wr_en;
	logic [2*CB-1:0]   rd_data;
	logic [CB-1:0]     rx, ry;

	logic [CB-1:0]     px_q, py_q;

	logic              v_s1, v_s2, v_s3;
	logic [SLOT_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [CB-1:0]     dx_s2, dy_s2, x_s2, y_s2, x_s3, y_s3;
	logic [SQW-1:0]    dx2_s3, dy2_s3;
	logic [SQW-1:0]    dxw, dyw;

	logic [DW-1:0]     sum;
	logic              take;
	logic [SLOT_W-1:0] best_idx_q;
	logic [DW-1:0]     best_d_q;
	logic [CB-1:0]     best_x_q, best_y_q;

	logic [15:0]       cx16, cy16;
	logic [31:0]       color32;
	logic              rsp_valid_q;

	// Seed write: only the low coordinate bits are kept, and slots beyond the
	// table are dropped.
	assign px_in    = CB'(req_item.coord_x);
	assign py_in    = CB'(req_item.coord_y);
	assign slot_ext = SW_EXT'(req_item.seed_slot);
	assign wr_en    = cmd.seed_wr && (32'(slot_ext) < 32'(MAX_SEEDS));

	nsvl_ram #(
		.WIDTH (2 * CB),
		.DEPTH (MAX_SEEDS)
	) u_seed_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_ext[SLOT_W-1:0]),
		.wr_data ({px_in, py_in}),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rx = rd_data[2*CB-1:CB];
	assign ry = rd_data[CB-1:0];

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign dxw = SQW'(dx_s2);
	assign dyw = SQW'(dy_s2);

	// Pixel capture, absolute differences, then squares.
	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			px_q <= px_in;
			py_q <= py_in;
		end
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		x_s2   <= rx;
		y_s2   <= ry;
		dx_s2  <= (rx >= px_q) ? (rx - px_q) : (px_q - rx);
		dy_s2  <= (ry >= py_q) ? (ry - py_q) : (py_q - ry);
		idx_s3 <= idx_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		dx2_s3 <= dxw * dxw;
		dy2_s3 <= dyw * dyw;
	end

	// Running minimum: entry 0 seeds it, later entries replace it only when
	// strictly closer, so ties keep the lowest index.
	assign sum  = DW'(dx2_s3) + DW'(dy2_s3);
	assign take = v_s3 && ((idx_s3 == '0) || (sum < best_d_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx_s3;
			best_d_q   <= sum;
			best_x_q   <= x_s3;
			best_y_q   <= y_s3;
		end
	end

	// Output register, freed by a transfer on the result channel.
	assign cx16    = 16'(best_x_q);
	assign cy16    = 16'(best_y_q);
	assign color32 = {cx16, 16'h0000} ^ {16'h0000, cy16};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_item.nearest_slot    <= SLOT_FW'(best_idx_q);
			rsp_item.nearest_dist_sq <= DIST_FW'(best_d_q);
			rsp_item.region_color    <= color32[COLOR_FW-1:0];
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

`ifndef ASSERT_OFF
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3) |-> (idx_s2 == idx_s3 + SLOT_W'(1)))
		else $error("distance pipeline entries out of order");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed_wr |-> !(v_s1 || v_s2 || v_s3))
		else $error("seed written while a search is in flight");
`endif

endmodule

`default_nettype wire

### sv/nearest_seed_voronoi_labeler.sv
// Nearest-seed labeller top level: a load item writes one seed slot without a stall; a query
// walks the first active_seeds table entries (at least one, at most MAX_SEEDS), one per
// cycle through the seed RAM read port. After a query, req_stall holds until the walk
// has drained and the result is loaded; a new item is taken the cycle after a load.
// The result waits in an output register while the next item is taken.
// arst_n clears the controller, the pipeline valid bits and sets active_seeds to 64.
// Depends on nsvl_pkg, nsvl_ctrl, nsvl_dp and nsvl_ram.
`default_nettype none

module nearest_seed_voronoi_labeler
	import nsvl_pkg::*;
#(
	parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire in_item_t              req_item,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output out_item_t                  rsp_item,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready
);

	localparam int SLOT_W = $clog2(MAX_SEEDS);

	logic [ACTIVE_W-1:0] active_seeds_q;
	logic                cfg_wr;
	logic [0:0]          reg_idx;
	ctrl_cmd_t           cmd;
	dp_status_t          sts;
	logic [SLOT_W-1:0]   rd_addr;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_ACTIVE_SEEDS) ? APB_DW'(active_seeds_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_seeds_q <= ACTIVE_SEEDS_RESET;
		end else if (cfg_wr && (reg_idx == REG_ACTIVE_SEEDS)) begin
			active_seeds_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	nsvl_ctrl #(
		.MAX_SEEDS (MAX_SEEDS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_opcode   (req_item.opcode),
		.req_stall    (req_stall),
		.active_seeds (active_seeds_q),
		.cmd          (cmd),
		.sts          (sts),
		.rd_addr      (rd_addr)
	);

	nsvl_dp #(
		.MAX_SEEDS  (MAX_SEEDS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.req_item  (req_item),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule

`default_nettype wire
